### rtl/core/mlprq_pkg.sv
// mlprq_pkg: shared types and constants of the multilevel priority ready queue
// holds the command and result transfer structs and the operation codes
// no dependencies
package mlprq_pkg;

	// default sizes of the queue
	localparam int LEVELS_DEF = 64;
	localparam int SLOTS_DEF  = 64;

	// operation codes carried in cmd_t.mode
	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DEQ  = 2'd1;
	localparam logic [1:0] MODE_MOVE = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] thread_id;
		logic [5:0] level;
		logic [5:0] from_level;
	} cmd_t;

	typedef struct packed {
		logic [5:0] out_thread;
		logic       got_thread;
		logic [5:0] top_level;
		logic [6:0] ready_count;
	} result_t;

endpackage

### rtl/core/multilevel_priority_ready_queue.sv
// multilevel_priority_ready_queue: thread ready queue with one fifo per priority level
// link memories, bitmaps and a two-step highest-level search under one sequencer
// depends on mlprq_pkg
module multilevel_priority_ready_queue #(
	parameter int LEVELS = mlprq_pkg::LEVELS_DEF,
	parameter int SLOTS  = mlprq_pkg::SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mlprq_pkg::cmd_t     cmd,
	output logic                done,
	output mlprq_pkg::result_t  result
);
	// a command is taken at a rising edge with start high and busy low; busy then
	// stays high while the sequencer works and the result appears for exactly one
	// cycle with done high, in the same cycle as busy falls. the receiver cannot
	// stall, so the result must be captured in that cycle. a new command may be
	// taken in the same cycle as the strobe. the pace of back-to-back transfers is
	// set by the single registered read port of each link memory (a read, then the
	// dependent writes) and by the highest-level search, which runs in two steps:
	// first the highest non-empty group of levels, then the highest level within
	// that group. the head, tail and link memories are not cleared after reset;
	// the level bitmap says which entries hold meaning, so the block is ready
	// straight out of reset.

	import mlprq_pkg::*;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	// search geometry: levels split into NG groups of G
	localparam int BW = (LW + 1) / 2;
	localparam int G  = 1 << BW;
	localparam int NG = (LEVELS + G - 1) / G;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_RD,
		ST_A_WR,
		ST_M_RD,
		ST_M_UL,
		ST_D_RD,
		ST_D_NX,
		ST_D_WR,
		ST_SRCH_G,
		ST_SRCH_B
	} state_t;

	state_t state_q;

	// command registers
	logic [SW-1:0] tix_q;
	logic [LW-1:0] lix_q;
	logic [LW-1:0] olix_q;
	logic          pre_q;   // search ahead of a dequeue
	logic [LW-1:0] top_q;
	logic [5:0]    popped_q;
	logic          got_q;

	// state of the queue
	logic [LEVELS-1:0] nonempty_q;
	logic [SLOTS-1:0]  queued_q;
	logic [CW-1:0]     cnt_q;

	// search registers
	logic [GW-1:0] grp_q;
	logic          any_q;

	// result registers
	logic    done_q;
	result_t result_q;

	// link memories
	logic [SW-1:0] head_mem_q [LEVELS];
	logic [SW-1:0] tail_mem_q [LEVELS];
	logic [SW-1:0] next_mem_q [SLOTS];
	logic [SW-1:0] prev_mem_q [SLOTS];
	logic [SW-1:0] head_rd_q, tail_rd_q, next_rd_q, prev_rd_q;

	logic [LW-1:0] head_ra, tail_ra, head_wa, tail_wa;
	logic [SW-1:0] next_ra, prev_ra, next_wa, prev_wa;
	logic [SW-1:0] head_wd, tail_wd, next_wd, prev_wd;
	logic          head_we, tail_we, next_we, prev_we;

	// incoming command decode
	logic [SW-1:0] tix_in;
	logic [LW-1:0] lix_in, olix_in;
	logic          t_ok, l_ok, ol_ok, enq_ok, move_ok;

	// unlink decode
	logic live, is_head, is_tail;

	// search unit
	logic [NG*G-1:0]       lvl_pad;
	logic [NG-1:0][G-1:0]  lvl_grp;
	logic [NG-1:0]         grp_any;
	logic [GW-1:0]         grp_sel;
	logic                  any_sel;
	logic [G-1:0]          grp_bits;
	logic [BW-1:0]         bit_sel;
	logic [LW-1:0]         top_lvl;

	assign tix_in  = SW'(32'(cmd.thread_id));
	assign lix_in  = LW'(32'(cmd.level));
	assign olix_in = LW'(32'(cmd.from_level));
	assign t_ok    = 32'(cmd.thread_id) < 32'(SLOTS);
	assign l_ok    = 32'(cmd.level) < 32'(LEVELS);
	assign ol_ok   = 32'(cmd.from_level) < 32'(LEVELS);
	assign enq_ok  = t_ok && l_ok && !queued_q[tix_in];
	assign move_ok = t_ok && l_ok && ol_ok && queued_q[tix_in];

	assign live    = nonempty_q[olix_q];
	assign is_head = live && (head_rd_q == tix_q);
	assign is_tail = live && (tail_rd_q == tix_q);

	// first search step: which group holds the highest set level
	assign lvl_pad = (NG*G)'(nonempty_q);
	assign lvl_grp = lvl_pad;

	always_comb begin
		grp_sel = '0;
		any_sel = 1'b0;
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |lvl_grp[g];
			if (grp_any[g]) begin
				grp_sel = GW'(g);
				any_sel = 1'b1;
			end
		end
	end

	// second search step: highest set level inside the chosen group
	assign grp_bits = lvl_grp[grp_q];

	always_comb begin
		bit_sel = '0;
		for (int b = 0; b < G; b++) begin
			if (grp_bits[b]) begin
				bit_sel = BW'(b);
			end
		end
	end

	assign top_lvl = any_q ? LW'(32'(grp_q) * G + 32'(bit_sel)) : '0;

	// read addresses follow the sequencer state
	always_comb begin
		head_ra = olix_q;
		tail_ra = olix_q;
		next_ra = tix_q;
		prev_ra = tix_q;
		case (state_q)
			ST_A_RD: begin
				tail_ra = lix_q;
			end
			ST_D_RD, ST_D_WR: begin
				head_ra = top_q;
				tail_ra = top_q;
			end
			ST_D_NX: begin
				head_ra = top_q;
				tail_ra = top_q;
				next_ra = head_rd_q;
			end
			default: begin
			end
		endcase
	end

	// link writes: append, unlink and pop
	always_comb begin
		head_we = 1'b0;
		tail_we = 1'b0;
		next_we = 1'b0;
		prev_we = 1'b0;
		head_wa = lix_q;
		tail_wa = lix_q;
		next_wa = tail_rd_q;
		prev_wa = tix_q;
		head_wd = tix_q;
		tail_wd = tix_q;
		next_wd = tix_q;
		prev_wd = tail_rd_q;
		case (state_q)
			ST_A_WR: begin
				if (nonempty_q[lix_q]) begin
					// link behind the current tail
					next_we = 1'b1;
					prev_we = 1'b1;
					tail_we = 1'b1;
				end else begin
					// level was empty, slot becomes head and tail
					head_we = 1'b1;
					tail_we = 1'b1;
				end
			end
			ST_M_UL: begin
				head_wa = olix_q;
				tail_wa = olix_q;
				head_wd = next_rd_q;
				tail_wd = prev_rd_q;
				next_wa = prev_rd_q;
				next_wd = next_rd_q;
				prev_wa = next_rd_q;
				prev_wd = prev_rd_q;
				if (is_head && is_tail) begin
					// level empties, bitmap only
				end else if (is_head) begin
					head_we = 1'b1;
				end else if (is_tail) begin
					tail_we = 1'b1;
				end else begin
					next_we = 1'b1;
					prev_we = 1'b1;
				end
			end
			ST_D_WR: begin
				head_wa = top_q;
				head_wd = next_rd_q;
				head_we = (tail_rd_q != head_rd_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem_q[head_wa] <= head_wd;
		end
		head_rd_q <= head_mem_q[head_ra];
	end

	always_ff @(posedge clk) begin
		if (tail_we) begin
			tail_mem_q[tail_wa] <= tail_wd;
		end
		tail_rd_q <= tail_mem_q[tail_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem_q[next_wa] <= next_wd;
		end
		next_rd_q <= next_mem_q[next_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem_q[prev_wa] <= prev_wd;
		end
		prev_rd_q <= prev_mem_q[prev_ra];
	end

	// sequencer, bitmaps, count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nonempty_q <= '0;
			queued_q   <= '0;
			cnt_q      <= '0;
			pre_q      <= 1'b0;
			done_q     <= 1'b0;
			got_q      <= 1'b0;
			popped_q   <= '0;
			any_q      <= 1'b0;
			grp_q      <= '0;
			top_q      <= '0;
			tix_q      <= '0;
			lix_q      <= '0;
			olix_q     <= '0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						tix_q    <= tix_in;
						lix_q    <= lix_in;
						olix_q   <= olix_in;
						popped_q <= '0;
						got_q    <= 1'b0;
						pre_q    <= 1'b0;
						if (cmd.mode == MODE_ENQ && enq_ok) begin
							state_q <= ST_A_RD;
						end else if (cmd.mode == MODE_MOVE && move_ok) begin
							state_q <= ST_M_RD;
						end else if (cmd.mode == MODE_DEQ) begin
							pre_q   <= 1'b1;
							state_q <= ST_SRCH_G;
						end else begin
							// ignored command, report the state as it is
							state_q <= ST_SRCH_G;
						end
					end
				end
				ST_A_RD: begin
					state_q <= ST_A_WR;
				end
				ST_A_WR: begin
					nonempty_q[lix_q] <= 1'b1;
					queued_q[tix_q]   <= 1'b1;
					cnt_q             <= cnt_q + CW'(1);
					state_q           <= ST_SRCH_G;
				end
				ST_M_RD: begin
					state_q <= ST_M_UL;
				end
				ST_M_UL: begin
					if (is_head && is_tail) begin
						nonempty_q[olix_q] <= 1'b0;
					end
					queued_q[tix_q] <= 1'b0;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
					// tail of the new level is read after the unlink writes land
					state_q <= ST_A_RD;
				end
				ST_D_RD: begin
					state_q <= ST_D_NX;
				end
				ST_D_NX: begin
					state_q <= ST_D_WR;
				end
				ST_D_WR: begin
					if (tail_rd_q == head_rd_q) begin
						nonempty_q[top_q] <= 1'b0;
					end
					queued_q[head_rd_q] <= 1'b0;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
					popped_q <= 6'(head_rd_q);
					got_q    <= 1'b1;
					state_q  <= ST_SRCH_G;
				end
				ST_SRCH_G: begin
					grp_q   <= grp_sel;
					any_q   <= any_sel;
					state_q <= ST_SRCH_B;
				end
				ST_SRCH_B: begin
					if (pre_q && any_q) begin
						// queue holds a thread: pop the head of the top level
						pre_q   <= 1'b0;
						top_q   <= top_lvl;
						state_q <= ST_D_RD;
					end else begin
						pre_q                <= 1'b0;
						result_q.out_thread  <= popped_q;
						result_q.got_thread  <= got_q;
						result_q.top_level   <= 6'(top_lvl);
						result_q.ready_count <= 7'(cnt_q);
						done_q               <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
